[rtl/ksp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksp_pkg
// Shared types and constants of the keyed sprite pixel blend unit.
// ----------------------------------------------------------------------------
package ksp_pkg;

   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int PIXEL_W     = 32;
   localparam int CHAN_W      = 8;
   localparam int SIZE_W      = 13;

   localparam logic [PIXEL_W-1:0] KEY_COLOR = 32'h00FF_00FF;
   localparam logic [CHAN_W-1:0]  CHAN_MAX  = 8'hFF;

   localparam logic [CHAN_W-1:0]  RST_BLEND_ALPHA = 8'd255;
   localparam logic [SIZE_W-1:0]  RST_DEST_WIDTH  = 13'd640;
   localparam logic [SIZE_W-1:0]  RST_DEST_HEIGHT = 13'd480;
   localparam logic [PIXEL_W-1:0] RST_FILL_COLOR  = 32'd0;
   localparam logic               RST_USE_GLYPH   = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLEND_ALPHA = 3'd0,
      CSR_DEST_WIDTH  = 3'd1,
      CSR_DEST_HEIGHT = 3'd2,
      CSR_FILL_COLOR  = 3'd3,
      CSR_USE_GLYPH   = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_COPY       = 2'd0,
      MODE_KEYED_COPY = 2'd1,
      MODE_KEYED_ADD  = 2'd2,
      MODE_TEXT       = 2'd3
   } mode_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  blend_alpha;
      logic [SIZE_W-1:0]  dest_width;
      logic [SIZE_W-1:0]  dest_height;
      logic [PIXEL_W-1:0] fill_color;
      logic               use_glyph_color;
   } cfg_type;

   typedef struct packed {
      logic               write_enable;
      logic [PIXEL_W-1:0] out_pixel;
   } result_type;

endpackage

[rtl/keyed_sprite_pixel_blend.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_sprite_pixel_blend
// Per-pixel write unit: clips the coordinate, skips the magenta key unless in
// copy mode; returns copy, additive blend or text paint, with write enable.
//
//   channel  handshake           payload
//   req      req_valid/ready     mode, src_pixel, dst_pixel, dest_x, dest_y
//   rsp      rsp_valid/ready     write_enable, out_pixel
//   csr      csr_we              csr_index, csr_wdata
//
// One word per cycle sustained while rsp is not stalled; a word taken into
// the input register passes the clip/blend logic (one 8x8 multiply per
// channel) into the result register, whose valid flag drives rsp_valid.
// Reset clears both valid flags and loads the csr reset values.
// A stalled rsp holds the result register; the input register then holds and
// req_ready drops once both are full.
// ----------------------------------------------------------------------------
module keyed_sprite_pixel_blend #(
   parameter int COORD_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_mode,
   input  logic [ksp_pkg::PIXEL_W-1:0]         req_src_pixel,
   input  logic [ksp_pkg::PIXEL_W-1:0]         req_dst_pixel,
   input  logic signed [COORD_BITS-1:0]        req_dest_x,
   input  logic signed [COORD_BITS-1:0]        req_dest_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_write_enable,
   output logic [ksp_pkg::PIXEL_W-1:0]         rsp_out_pixel,
   input  logic                                csr_we,
   input  logic [ksp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ksp_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ksp_pkg::*;

   cfg_type               cfg;
   result_type            calc_result;

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [1:0]            mode_ff;
   logic [PIXEL_W-1:0]    src_ff;
   logic [PIXEL_W-1:0]    dst_ff;
   logic [COORD_BITS-1:0] x_ff;
   logic [COORD_BITS-1:0] y_ff;

   logic                  out_valid_ff;
   logic                  out_valid_in;
   result_type            out_ff;

   logic                  out_free;
   logic                  advance;
   logic                  req_take;

   ksp_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ksp_pixel_calc #(
      .COORD_BITS (COORD_BITS)
   ) u_calc (
      .cfg       (cfg),
      .mode      (mode_ff),
      .src_pixel (src_ff),
      .dst_pixel (dst_ff),
      .dest_x    (x_ff),
      .dest_y    (y_ff),
      .result    (calc_result)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff <= req_mode;
         src_ff  <= req_src_pixel;
         dst_ff  <= req_dst_pixel;
         x_ff    <= req_dest_x;
         y_ff    <= req_dest_y;
      end
      if (advance) begin
         out_ff <= calc_result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_write_enable = out_ff.write_enable;
   assign rsp_out_pixel    = out_ff.out_pixel;

endmodule

[rtl/ksp_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksp_cfg_regs
// Configuration register file, written through the plain csr write port.
// ----------------------------------------------------------------------------
module ksp_cfg_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ksp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ksp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output ksp_pkg::cfg_type                    cfg
);
   import ksp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_BLEND_ALPHA: cfg_in.blend_alpha     = csr_wdata[CHAN_W-1:0];
            CSR_DEST_WIDTH:  cfg_in.dest_width      = csr_wdata[SIZE_W-1:0];
            CSR_DEST_HEIGHT: cfg_in.dest_height     = csr_wdata[SIZE_W-1:0];
            CSR_FILL_COLOR:  cfg_in.fill_color      = csr_wdata[PIXEL_W-1:0];
            CSR_USE_GLYPH:   cfg_in.use_glyph_color = csr_wdata[0];
            default: ;  // drop writes to unmapped indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blend_alpha     <= RST_BLEND_ALPHA;
         cfg_ff.dest_width      <= RST_DEST_WIDTH;
         cfg_ff.dest_height     <= RST_DEST_HEIGHT;
         cfg_ff.fill_color      <= RST_FILL_COLOR;
         cfg_ff.use_glyph_color <= RST_USE_GLYPH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/ksp_pixel_calc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksp_pixel_calc
// Clip, key test and per-mode pixel value for one registered input word.
// ----------------------------------------------------------------------------
module ksp_pixel_calc #(
   parameter int COORD_BITS = 16
) (
   input  ksp_pkg::cfg_type                    cfg,
   input  logic [1:0]                          mode,
   input  logic [ksp_pkg::PIXEL_W-1:0]         src_pixel,
   input  logic [ksp_pkg::PIXEL_W-1:0]         dst_pixel,
   input  logic [COORD_BITS-1:0]               dest_x,
   input  logic [COORD_BITS-1:0]               dest_y,
   output ksp_pkg::result_type                 result
);
   import ksp_pkg::*;

   localparam int CMP_W = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;

   // d + s*a/255, saturated; x/255 = (x + (x >> 8) + 1) >> 8 for 16-bit products
   function automatic logic [CHAN_W-1:0] add_chan(input logic [CHAN_W-1:0] s,
                                                  input logic [CHAN_W-1:0] d,
                                                  input logic [CHAN_W-1:0] a);
      logic [2*CHAN_W-1:0] prod;
      logic [2*CHAN_W:0]   acc;
      logic [CHAN_W-1:0]   quo;
      logic [CHAN_W:0]     tot;
      prod = s * a;
      acc  = {1'b0, prod} + (2*CHAN_W+1)'(prod[2*CHAN_W-1:CHAN_W]) + (2*CHAN_W+1)'(1);
      quo  = acc[2*CHAN_W-1:CHAN_W];
      tot  = {1'b0, d} + {1'b0, quo};
      return tot[CHAN_W] ? CHAN_MAX : tot[CHAN_W-1:0];
   endfunction

   logic                  inside_x;
   logic                  inside_y;
   logic                  keyed;
   logic                  we;
   logic [PIXEL_W-1:0]    add_pixel;
   logic [PIXEL_W-1:0]    pix;
   mode_type              mode_sel;

   assign mode_sel = mode_type'(mode);

   // a set sign bit means a negative coordinate, outside in any case
   assign inside_x = !dest_x[COORD_BITS-1] &&
                     (CMP_W'(dest_x) < CMP_W'(cfg.dest_width));
   assign inside_y = !dest_y[COORD_BITS-1] &&
                     (CMP_W'(dest_y) < CMP_W'(cfg.dest_height));

   assign keyed = (mode_sel != MODE_COPY) && (src_pixel == KEY_COLOR);
   assign we    = inside_x && inside_y && !keyed;

   assign add_pixel = {8'h00,
                       add_chan(src_pixel[23:16], dst_pixel[23:16], cfg.blend_alpha),
                       add_chan(src_pixel[15:8],  dst_pixel[15:8],  cfg.blend_alpha),
                       add_chan(src_pixel[7:0],   dst_pixel[7:0],   cfg.blend_alpha)};

   always_comb begin
      case (mode_sel)
         MODE_COPY, MODE_KEYED_COPY: pix = src_pixel;
         MODE_KEYED_ADD:             pix = add_pixel;
         MODE_TEXT:                  pix = cfg.use_glyph_color ? src_pixel : cfg.fill_color;
         default:                    pix = src_pixel;
      endcase
   end

   assign result.write_enable = we;
   assign result.out_pixel    = we ? pix : '0;

endmodule

[rtl/ksp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksp_checker
// Port-level checks on the req and rsp channels of the pixel blend unit.
// ----------------------------------------------------------------------------
module ksp_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                rsp_write_enable,
   input  logic [ksp_pkg::PIXEL_W-1:0]         rsp_out_pixel
);
   import ksp_pkg::*;

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_enable) &&
                                   $stable(rsp_out_pixel))
      else $error("rsp word changed while stalled");

   // skipped pixel carries a zero value
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_out_pixel == '0)
      else $error("skipped pixel with nonzero value");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // with rsp idle now and at the prior sample and no word taken, the pipe is
   // empty and the unit must take a word
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!rsp_valid) && !$past(reset) && !$past(req_valid && req_ready)
         |-> req_ready)
      else $error("req stalled with an empty pipe");

endmodule

bind keyed_sprite_pixel_blend ksp_checker u_ksp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_write_enable (rsp_write_enable),
   .rsp_out_pixel    (rsp_out_pixel)
);

[dv/keyed_sprite_pixel_blend_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_sprite_pixel_blend_tb
// Drives pixel words through the blend unit. A local copy of the register
// file and a predictor compute each expected write enable and pixel. Results
// are checked in order. A directed part covers clipping edges, the magenta
// key, additive saturation and text paint. Random phases then run with new
// register settings; all but the last may add random req gaps and rsp stalls.
// ----------------------------------------------------------------------------
module keyed_sprite_pixel_blend_tb;
   import ksp_pkg::*;

   localparam int COORD_W       = 16;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_PIXELS  = 85;
   localparam int MAX_REPORTS   = 30;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [1:0]                 req_mode;
   logic [PIXEL_W-1:0]         req_src_pixel;
   logic [PIXEL_W-1:0]         req_dst_pixel;
   logic signed [COORD_W-1:0]  req_dest_x;
   logic signed [COORD_W-1:0]  req_dest_y;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic                       rsp_write_enable;
   logic [PIXEL_W-1:0]         rsp_out_pixel;
   logic                       csr_we;
   logic [CSR_INDEX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;

   cfg_type     shadow_cfg;
   result_type  pending_pixels[$];
   result_type  checked_word;
   int          mismatch_count;
   int          quiet_cycles;
   bit          gaps_on;
   bit          stalls_on;

   keyed_sprite_pixel_blend #(.COORD_BITS(COORD_W)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_src_pixel    (req_src_pixel),
      .req_dst_pixel    (req_dst_pixel),
      .req_dest_x       (req_dest_x),
      .req_dest_y       (req_dest_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_write_enable (rsp_write_enable),
      .rsp_out_pixel    (rsp_out_pixel),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [CHAN_W-1:0] add_saturate(input logic [CHAN_W-1:0] s,
                                                      input logic [CHAN_W-1:0] d,
                                                      input logic [CHAN_W-1:0] a);
      int sum;
      sum = int'(d) + (int'(s) * int'(a)) / int'(CHAN_MAX);
      return (sum > int'(CHAN_MAX)) ? CHAN_MAX : sum[CHAN_W-1:0];
   endfunction

   function automatic result_type predict_pixel(input mode_type m,
                                                input logic [PIXEL_W-1:0] src,
                                                input logic [PIXEL_W-1:0] dst,
                                                input logic signed [COORD_W-1:0] x,
                                                input logic signed [COORD_W-1:0] y);
      result_type r;
      int xi;
      int yi;
      xi = int'(x);
      yi = int'(y);
      r.write_enable = (xi >= 0) && (yi >= 0) &&
                       (xi < int'(shadow_cfg.dest_width)) &&
                       (yi < int'(shadow_cfg.dest_height));
      if (m != MODE_COPY && src == KEY_COLOR)
         r.write_enable = 1'b0;
      r.out_pixel = '0;
      if (r.write_enable) begin
         case (m)
            MODE_COPY, MODE_KEYED_COPY: begin
               r.out_pixel = src;
            end
            MODE_KEYED_ADD: begin
               r.out_pixel = {8'h00,
                  add_saturate(src[23:16], dst[23:16], shadow_cfg.blend_alpha),
                  add_saturate(src[15:8],  dst[15:8],  shadow_cfg.blend_alpha),
                  add_saturate(src[7:0],   dst[7:0],   shadow_cfg.blend_alpha)};
            end
            default: begin
               r.out_pixel = shadow_cfg.use_glyph_color ? src : shadow_cfg.fill_color;
            end
         endcase
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic send_pixel(input mode_type m,
                             input logic [PIXEL_W-1:0] src,
                             input logic [PIXEL_W-1:0] dst,
                             input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
      int gap;
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_mode      = m;
      req_src_pixel = src;
      req_dst_pixel = dst;
      req_dest_x    = x;
      req_dest_y    = y;
      do @(posedge clock); while (!req_ready);
      pending_pixels.push_back(predict_pixel(m, src, dst, x, y));
   endtask

   // drop valid and wait for every expected word to come back
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         CSR_BLEND_ALPHA: shadow_cfg.blend_alpha     = data[CHAN_W-1:0];
         CSR_DEST_WIDTH:  shadow_cfg.dest_width      = data[SIZE_W-1:0];
         CSR_DEST_HEIGHT: shadow_cfg.dest_height     = data[SIZE_W-1:0];
         CSR_FILL_COLOR:  shadow_cfg.fill_color      = data;
         CSR_USE_GLYPH:   shadow_cfg.use_glyph_color = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // junk above each register's width must be ignored
   task automatic set_config(input logic [CHAN_W-1:0] alpha,
                             input logic [SIZE_W-1:0] width,
                             input logic [SIZE_W-1:0] height,
                             input logic [PIXEL_W-1:0] fill,
                             input logic glyph);
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom;
      write_reg(CSR_BLEND_ALPHA, {junk[31:CHAN_W], alpha});
      junk = $urandom;
      write_reg(CSR_DEST_WIDTH, {junk[31:SIZE_W], width});
      junk = $urandom;
      write_reg(CSR_DEST_HEIGHT, {junk[31:SIZE_W], height});
      write_reg(CSR_FILL_COLOR, fill);
      junk = $urandom;
      write_reg(CSR_USE_GLYPH, {junk[31:1], glyph});
   endtask

   initial begin
      int gap;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stalls_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            rsp_ready = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- checking
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected word we=%0b pixel=%08h",
                                      rsp_write_enable, rsp_out_pixel));
         end else begin
            checked_word = pending_pixels.pop_front();
            if (rsp_write_enable !== checked_word.write_enable)
               report_mismatch($sformatf("write_enable got %0b want %0b",
                                         rsp_write_enable, checked_word.write_enable));
            if (rsp_out_pixel !== checked_word.out_pixel)
               report_mismatch($sformatf("out_pixel got %08h want %08h",
                                         rsp_out_pixel, checked_word.out_pixel));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_reset_defaults();
      send_pixel(MODE_COPY,       32'hFF12_3456, 32'h0000_0000, 639, 479);
      send_pixel(MODE_KEYED_COPY, 32'h00AB_CDEF, 32'h0011_2233, 640, 0);
      send_pixel(MODE_TEXT,       32'h00C0_FFEE, 32'h0000_0000, 0,   480);
      send_pixel(MODE_TEXT,       32'h80C0_FFEE, 32'h0000_0000, 10,  10);
      send_pixel(MODE_KEYED_ADD,  32'h00FF_FFFF, 32'h0001_0203, 5,   5);
   endtask

   task automatic test_clip_bounds();
      settle();
      set_config(8'd255, 13'd1, 13'd1, 32'h0, 1'b1);
      send_pixel(MODE_COPY, 32'h0012_3456, 32'h0, 0,  0);
      send_pixel(MODE_COPY, 32'h0012_3456, 32'h0, 1,  0);
      send_pixel(MODE_COPY, 32'h0012_3456, 32'h0, 0,  1);
      send_pixel(MODE_COPY, 32'h0012_3456, 32'h0, -1, 0);
      send_pixel(MODE_COPY, 32'h0012_3456, 32'h0, 16'sh8000, 16'sh7FFF);
      // zero width clips everything
      settle();
      set_config(8'd255, 13'd0, 13'd4096, 32'h0, 1'b1);
      send_pixel(MODE_COPY, 32'h0012_3456, 32'h0, 0, 0);
      settle();
      set_config(8'd255, 13'h1FFF, 13'h1FFF, 32'h0, 1'b1);
      send_pixel(MODE_COPY, 32'hFFFF_FFFF, 32'h0, 8190, 8190);
      send_pixel(MODE_COPY, 32'hFFFF_FFFF, 32'h0, 8191, 0);
      send_pixel(MODE_COPY, 32'hFFFF_FFFF, 32'h0, 16'sh7FFF, 0);
   endtask

   task automatic test_color_key();
      settle();
      set_config(8'd255, 13'd640, 13'd480, 32'hDEAD_BEEF, 1'b0);
      send_pixel(MODE_COPY,       KEY_COLOR, 32'h0000_0000, 1, 1);
      send_pixel(MODE_KEYED_COPY, KEY_COLOR, 32'h0000_0000, 1, 1);
      send_pixel(MODE_KEYED_ADD,  KEY_COLOR, 32'h0000_0000, 1, 1);
      send_pixel(MODE_TEXT,       KEY_COLOR, 32'h0000_0000, 1, 1);
      // near misses: the key compares all 32 bits
      send_pixel(MODE_KEYED_COPY, 32'h01FF_00FF, 32'h0, 2, 2);
      send_pixel(MODE_TEXT,       32'h00FF_00FE, 32'h0, 2, 2);
   endtask

   task automatic test_additive();
      settle();
      set_config(8'd0, 13'd640, 13'd480, 32'h0, 1'b1);
      send_pixel(MODE_KEYED_ADD, 32'hFFFF_FFFF, 32'h1234_5678, 3, 3);
      settle();
      set_config(8'd128, 13'd640, 13'd480, 32'h0, 1'b1);
      send_pixel(MODE_KEYED_ADD, 32'hFF80_8001, 32'hAA7F_8000, 3, 3);
      settle();
      set_config(8'd255, 13'd640, 13'd480, 32'h0, 1'b1);
      send_pixel(MODE_KEYED_ADD, 32'h0001_0101, 32'h00FE_FFFE, 3, 3);
      settle();
      set_config(8'd1, 13'd640, 13'd480, 32'h0, 1'b1);
      send_pixel(MODE_KEYED_ADD, 32'h00FF_FFFF, 32'h00FF_0000, 3, 3);
   endtask

   task automatic test_text_paint();
      settle();
      set_config(8'd255, 13'd640, 13'd480, 32'hFFFF_FFFF, 1'b0);
      send_pixel(MODE_TEXT, 32'h0055_AA55, 32'h0, 7, 7);
      settle();
      set_config(8'd255, 13'd640, 13'd480, 32'h0000_0000, 1'b1);
      send_pixel(MODE_TEXT, 32'hFF00_0000, 32'h0, 7, 7);
   endtask

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 7))
         0:       return 13'd0;
         1:       return 13'd1;
         2:       return 13'd4096;
         3:       return 13'h1FFF;
         default: return SIZE_W'($urandom_range(1, 64));
      endcase
   endfunction

   function automatic logic [CHAN_W-1:0] pick_channel();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   function automatic logic [PIXEL_W-1:0] pick_pixel();
      logic [7:0] top;
      top = 8'($urandom);
      if ($urandom_range(0, 7) == 0)
         return KEY_COLOR;
      if ($urandom_range(0, 1) == 0)
         top = 8'h00;
      return {top, pick_channel(), pick_channel(), pick_channel()};
   endfunction

   // mostly near or inside the bitmap, with some from the whole range
   function automatic logic signed [COORD_W-1:0] pick_coord(input int span);
      int v;
      case ($urandom_range(0, 9))
         7, 8:    v = $urandom;
         9:       v = $urandom_range(0, 1) ? 32767 : -32768;
         default: v = int'($urandom_range(0, span + 1)) - 1;
      endcase
      return v[COORD_W-1:0];
   endfunction

   task automatic test_random_traffic();
      logic [CHAN_W-1:0] alpha;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         case ($urandom_range(0, 3))
            0:       alpha = 8'd0;
            1:       alpha = 8'd255;
            default: alpha = CHAN_W'($urandom);
         endcase
         set_config(alpha, pick_size(), pick_size(), $urandom, 1'($urandom_range(0, 1)));
         if (phase == RANDOM_PHASES - 1) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end else begin
            gaps_on   = $urandom_range(0, 4) != 0;
            stalls_on = $urandom_range(0, 4) != 0;
         end
         for (int n = 0; n < PHASE_PIXELS; n++)
            send_pixel(mode_type'($urandom_range(0, 3)), pick_pixel(), pick_pixel(),
                       pick_coord(int'(shadow_cfg.dest_width)),
                       pick_coord(int'(shadow_cfg.dest_height)));
      end
   endtask

   initial begin
      req_valid      = 1'b0;
      req_mode       = MODE_COPY;
      req_src_pixel  = '0;
      req_dst_pixel  = '0;
      req_dest_x     = '0;
      req_dest_y     = '0;
      csr_we         = 1'b0;
      csr_index      = CSR_BLEND_ALPHA;
      csr_wdata      = '0;
      reset          = 1'b1;
      gaps_on        = 1'b1;
      stalls_on      = 1'b1;
      mismatch_count = 0;
      shadow_cfg.blend_alpha     = RST_BLEND_ALPHA;
      shadow_cfg.dest_width      = RST_DEST_WIDTH;
      shadow_cfg.dest_height     = RST_DEST_HEIGHT;
      shadow_cfg.fill_color      = RST_FILL_COLOR;
      shadow_cfg.use_glyph_color = RST_USE_GLYPH;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_clip_bounds();
      test_color_key();
      test_additive();
      test_text_paint();
      test_random_traffic();
      settle();

      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[keyed_sprite_pixel_blend.f]
rtl/ksp_pkg.sv
rtl/ksp_cfg_regs.sv
rtl/ksp_pixel_calc.sv
rtl/keyed_sprite_pixel_blend.sv
rtl/ksp_checker.sv
dv/keyed_sprite_pixel_blend_tb.sv
